// ===== hw/rtl/mmt_pkg.sv =====
// Shared types and constants for the matrix-by-transpose multiplier.
// Used by mmt_store, mmt_seq, mmt_mac and matrix_multiply_by_transpose.
package mmt_pkg;

   // Parameter defaults
   localparam int MAX_ROWS_DEFAULT = 8;
   localparam int MAX_LEN_DEFAULT  = 16;

   // Field widths
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 32;
   localparam int ACC_W   = 40;   // holds 64 full-scale products without wrap
   localparam int DOT_W   = 36;
   localparam int ROW_W   = 3;
   localparam int COL_W   = 4;
   localparam int CNT_W   = 4;    // row count registers
   localparam int LEN_W   = 5;    // inner length register
   localparam int PADDR_W = 4;

   // Saturation limits of the 36-bit signed result
   localparam logic signed [ACC_W-1:0] DOT_MAX = 40'sh07_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] DOT_MIN = -40'sh08_0000_0000;

   // Register reset values
   localparam logic [CNT_W-1:0] A_ROWS_RESET = 4'd8;
   localparam logic [LEN_W-1:0] LEN_RESET    = 5'd16;
   localparam logic [CNT_W-1:0] B_ROWS_RESET = 4'd8;

   // Register indexes (paddr[3:2])
   typedef enum logic [1:0] {
      REG_A_ROWS = 2'd0,
      REG_LEN    = 2'd1,
      REG_B_ROWS = 2'd2,
      REG_NONE   = 2'd3
   } reg_index_type;

   // Request function codes
   typedef enum logic [1:0] {
      FUNC_WRITE_A = 2'd0,
      FUNC_WRITE_B = 2'd1,
      FUNC_START   = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   // Control tag that travels with each multiply-accumulate step
   typedef struct packed {
      logic             valid;
      logic             first;     // first term of a dot product
      logic             last_term; // last term: emit the sum
      logic             last_all;  // last term of the whole run
      logic             zero;      // empty inner length: force the term to zero
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
   } mmt_tag_type;

endpackage

// ===== hw/rtl/mmt_store.sv =====
// Element store: one write port, one registered read port.
// Depends on mmt_pkg for the element width.
module mmt_store
   import mmt_pkg::*;
#(
   parameter int DEPTH  = MAX_ROWS_DEFAULT * MAX_LEN_DEFAULT,
   parameter int ADDR_W = $clog2(MAX_ROWS_DEFAULT * MAX_LEN_DEFAULT)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ELEM_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ELEM_W-1:0] rd_data
);

   logic [ELEM_W-1:0] mem [DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mmt_seq.sv =====
// Sequencer: clearing pass after reset, then the row/row/term walk of a run.
// Depends on mmt_pkg for the step tag.
module mmt_seq
   import mmt_pkg::*;
#(
   parameter int MAX_LEN  = MAX_LEN_DEFAULT,
   parameter int DEPTH    = MAX_ROWS_DEFAULT * MAX_LEN_DEFAULT,
   parameter int ADDR_W   = $clog2(MAX_ROWS_DEFAULT * MAX_LEN_DEFAULT),
   parameter int K_W      = $clog2(MAX_LEN_DEFAULT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [ROW_W-1:0]  m_last,
   input  logic [ROW_W-1:0]  n_last,
   input  logic [K_W-1:0]    len_last,
   input  logic              len_zero,
   input  logic              run_done,
   output logic              busy,
   output logic              clear_en,
   output logic [ADDR_W-1:0] clear_addr,
   output logic [ADDR_W-1:0] a_addr,
   output logic [ADDR_W-1:0] b_addr,
   output mmt_tag_type       tag
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLEAR = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ROW_W-1:0]  i_ff, i_in;
   logic [ROW_W-1:0]  j_ff, j_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic              last_k, last_j, last_i;

   assign last_k = (k_ff == len_last);
   assign last_j = (j_ff == n_last);
   assign last_i = (i_ff == m_last);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            k_in = k_ff + 1'b1;
            if (last_k) begin
               k_in = '0;
               j_in = j_ff + 1'b1;
               if (last_j) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
                  if (last_i) begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (run_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign clear_en   = (state_ff == ST_CLEAR);
   assign clear_addr = clr_ff;
   assign a_addr     = ADDR_W'(32'(i_ff) * MAX_LEN + 32'(k_ff));
   assign b_addr     = ADDR_W'(32'(j_ff) * MAX_LEN + 32'(k_ff));

   always_comb begin
      tag.valid     = (state_ff == ST_RUN);
      tag.first     = (k_ff == '0);
      tag.last_term = last_k;
      tag.last_all  = last_k && last_j && last_i;
      tag.zero      = len_zero;
      tag.row       = i_ff;
      tag.col       = j_ff;
   end

endmodule

// ===== hw/rtl/mmt_mac.sv =====
// Shared multiply-accumulate unit with saturation and result register.
// Depends on mmt_pkg for widths, limits and the step tag.
module mmt_mac
   import mmt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mmt_tag_type             tag,       // aligned with the read addresses
   input  logic [ELEM_W-1:0]       a_data,    // registered read, in the cycle after the tag
   input  logic [ELEM_W-1:0]       b_data,
   output logic                    rsp_valid,
   output logic signed [DOT_W-1:0] rsp_dot_value,
   output logic [ROW_W-1:0]        rsp_out_row,
   output logic [ROW_W-1:0]        rsp_out_col,
   output logic                    rsp_last
);

   mmt_tag_type              tag_d1_ff, tag_d2_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, term;
   logic                     valid_ff;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [ROW_W-1:0]         row_ff, col_ff;
   logic                     last_ff;

   assign prod_in = $signed(a_data) * $signed(b_data);

   always_comb begin
      term   = tag_d2_ff.zero ? '0 : ACC_W'(prod_ff);
      acc_in = tag_d2_ff.first ? term : acc_ff + term;
      if (acc_in > DOT_MAX) begin
         dot_in = DOT_W'(DOT_MAX);
      end else if (acc_in < DOT_MIN) begin
         dot_in = DOT_W'(DOT_MIN);
      end else begin
         dot_in = acc_in[DOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d1_ff <= '0;
         tag_d2_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         tag_d1_ff <= tag;
         tag_d2_ff <= tag_d1_ff;
         valid_ff  <= tag_d2_ff.valid && tag_d2_ff.last_term;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (tag_d2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (tag_d2_ff.valid && tag_d2_ff.last_term) begin
         dot_ff  <= dot_in;
         row_ff  <= tag_d2_ff.row;
         col_ff  <= tag_d2_ff.col;
         last_ff <= tag_d2_ff.last_all;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_dot_value = dot_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== hw/rtl/matrix_multiply_by_transpose.sv =====
// A start request's first result follows its first l terms (l = inner length, at least 1)
// through the store read, product and result registers; busy drops after the last result.
// Throughput: loads are taken one per cycle while busy is low; a run occupies the single MAC
// unit with one term per cycle, set by the one multiplier and store read port.
// Reset: synchronous; a clearing pass over all MAX_ROWS*MAX_LEN addresses zeroes both stores
// with busy high. Results cannot be stalled: each shows for one cycle on rsp_valid.
module matrix_multiply_by_transpose
   import mmt_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_LEN  = MAX_LEN_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_func,
   input  logic [ROW_W-1:0]        req_row_index,
   input  logic [COL_W-1:0]        req_col_index,
   input  logic signed [ELEM_W-1:0] req_elem_value,
   // result channel
   output logic                    rsp_valid,
   output logic signed [DOT_W-1:0] rsp_dot_value,
   output logic [ROW_W-1:0]        rsp_out_row,
   output logic [ROW_W-1:0]        rsp_out_col,
   output logic                    rsp_last,
   // register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [PADDR_W-1:0]      paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int DEPTH  = MAX_ROWS * MAX_LEN;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int K_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // Configuration registers
   logic [CNT_W-1:0] a_rows_ff, b_rows_ff;
   logic [LEN_W-1:0] len_ff;
   logic             cfg_write;
   reg_index_type    cfg_idx;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_idx   = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= A_ROWS_RESET;
         len_ff    <= LEN_RESET;
         b_rows_ff <= B_ROWS_RESET;
      end else if (cfg_write) begin
         unique case (cfg_idx)
            REG_A_ROWS: a_rows_ff <= pwdata[CNT_W-1:0];
            REG_LEN:    len_ff    <= pwdata[LEN_W-1:0];
            REG_B_ROWS: b_rows_ff <= pwdata[CNT_W-1:0];
            default:    ;   // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_A_ROWS: prdata = 32'(a_rows_ff);
         REG_LEN:    prdata = 32'(len_ff);
         REG_B_ROWS: prdata = 32'(b_rows_ff);
         default:    prdata = '0;
      endcase
   end

   // Clamp the counts to the store size and form the loop bounds
   logic [CNT_W-1:0] m_clamp, n_clamp;
   logic [6:0]       len_clamp;
   logic [ROW_W-1:0] m_last, n_last;
   logic [K_W-1:0]   len_last;
   logic             len_zero;

   always_comb begin
      m_clamp   = (32'(a_rows_ff) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : a_rows_ff;
      n_clamp   = (32'(b_rows_ff) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : b_rows_ff;
      len_clamp = (32'(len_ff) > MAX_LEN) ? 7'(MAX_LEN) : 7'(len_ff);
      m_last    = ROW_W'(m_clamp - 1'b1);
      n_last    = ROW_W'(n_clamp - 1'b1);
      len_zero  = (len_clamp == '0);
      // an empty inner length still walks one forced-zero term per result
      len_last  = len_zero ? '0 : K_W'(len_clamp - 7'd1);
   end

   // Accept requests; loads write at once, a start hands over to the sequencer
   logic     accept, go, load_a, load_b, load_in_range;
   func_type func;

   assign func          = func_type'(req_func);
   assign accept        = start && !busy;
   assign load_in_range = (32'(req_row_index) < MAX_ROWS) && (32'(req_col_index) < MAX_LEN);
   assign load_a        = accept && (func == FUNC_WRITE_A) && load_in_range;
   assign load_b        = accept && (func == FUNC_WRITE_B) && load_in_range;
   assign go            = accept && (func == FUNC_START) && (m_clamp != '0) && (n_clamp != '0);

   logic [ADDR_W-1:0] load_addr;
   assign load_addr = ADDR_W'(32'(req_row_index) * MAX_LEN + 32'(req_col_index));

   // Sequencer
   logic              clear_en, run_done;
   logic [ADDR_W-1:0] clear_addr, a_addr, b_addr;
   mmt_tag_type       tag;

   assign run_done = rsp_valid && rsp_last;

   mmt_seq #(
      .MAX_LEN  (MAX_LEN),
      .DEPTH    (DEPTH),
      .ADDR_W   (ADDR_W),
      .K_W      (K_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .m_last     (m_last),
      .n_last     (n_last),
      .len_last   (len_last),
      .len_zero   (len_zero),
      .run_done   (run_done),
      .busy       (busy),
      .clear_en   (clear_en),
      .clear_addr (clear_addr),
      .a_addr     (a_addr),
      .b_addr     (b_addr),
      .tag        (tag)
   );

   // Stores: the clearing pass owns the write port until it finishes
   logic [ADDR_W-1:0] wr_addr;
   logic [ELEM_W-1:0] wr_data, a_data, b_data;

   assign wr_addr = clear_en ? clear_addr : load_addr;
   assign wr_data = clear_en ? '0 : req_elem_value;

   mmt_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (clear_en || load_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   mmt_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (clear_en || load_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   // Shared multiply-accumulate and result register
   mmt_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .tag           (tag),
      .a_data        (a_data),
      .b_data        (b_data),
      .rsp_valid     (rsp_valid),
      .rsp_dot_value (rsp_dot_value),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_last      (rsp_last)
   );

endmodule
